### design/edcp_pkg.sv
package edcp_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] CMD_RESET  = 8'h10;
  localparam logic [7:0] CMD_SET    = 8'h11;

  localparam logic [1:0] ACT_POLL = 2'd0;
  localparam logic [1:0] ACT_KNOB = 2'd1;

  localparam logic [1:0] REG_SEND_INTERVAL = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE      = 2'd1;

  localparam logic [15:0] SEND_INTERVAL_RESET = 16'd20;
  localparam logic [15:0] DEBOUNCE_RESET      = 16'd50;

  localparam logic [7:0] POS_LIMIT = 8'h7F;
  localparam logic [7:0] NEG_LIMIT = 8'h80;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] counter_sample;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } out_item_t;

  // one queued packet: command and operand; start byte and checksum are implied
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] operand;
  } pkt_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/edcp_front.sv
module edcp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  edcp_pkg::in_item_t in_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output edcp_pkg::pkt_t     q_data
);
  import edcp_pkg::*;

  logic [15:0] send_interval;
  logic [15:0] debounce;
  logic [31:0] reference_count;
  logic [31:0] last_send_time;
  logic [31:0] last_press_time;

  logic [31:0] delta;
  logic [31:0] send_elapsed;
  logic [31:0] press_elapsed;
  logic        accept;
  logic        send_set;
  logic        send_reset;
  logic [7:0]  operand;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign delta         = in_item.counter_sample - reference_count;
  assign send_elapsed  = in_item.now_ms - last_send_time;
  assign press_elapsed = in_item.now_ms - last_press_time;

  assign send_set = (in_item.action == ACT_POLL) && (delta != 32'd0)
                    && (send_elapsed >= {16'd0, send_interval});
  assign send_reset = (in_item.action == ACT_KNOB)
                      && (press_elapsed >= {16'd0, debounce});

  // saturate the signed 32-bit movement to a signed byte
  always_comb begin
    if (delta[31]) begin
      operand = (&delta[31:7]) ? delta[7:0] : NEG_LIMIT;
    end else begin
      operand = (|delta[31:7]) ? POS_LIMIT : delta[7:0];
    end
  end

  assign q_push = accept && (send_set || send_reset);
  assign q_data = '{cmd:     (send_set ? CMD_SET : CMD_RESET),
                    operand: (send_set ? operand : 8'h00)};

  always_ff @(posedge clk) begin
    if (rst) begin
      send_interval   <= SEND_INTERVAL_RESET;
      debounce        <= DEBOUNCE_RESET;
      reference_count <= '0;
      last_send_time  <= '0;
      last_press_time <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SEND_INTERVAL) begin
          send_interval <= cfg_data;
        end else if (cfg_index == REG_DEBOUNCE) begin
          debounce <= cfg_data;
        end
      end
      if (accept && send_set) begin
        reference_count <= in_item.counter_sample;
        last_send_time  <= in_item.now_ms;
      end
      if (accept && send_reset) begin
        last_press_time <= in_item.now_ms;
      end
    end
  end

endmodule

### design/edcp_queue.sv
module edcp_queue (
  input  logic              clk,
  input  logic              rst,
  input  edcp_pkg::q_ctrl_t ctrl,
  input  edcp_pkg::pkt_t    wr_data,
  output edcp_pkg::pkt_t    rd_data,
  output edcp_pkg::q_stat_t stat
);
  import edcp_pkg::*;

  pkt_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign rd_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/edcp_back.sv
module edcp_back (
  input  logic                clk,
  input  logic                rst,
  input  edcp_pkg::pkt_t      q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output edcp_pkg::out_item_t out_item
);
  import edcp_pkg::*;

  logic [1:0] byte_idx;   // next byte to send of the current packet; 0 = none active
  pkt_t       cur;
  logic       advance;
  logic [7:0] next_byte;

  assign advance = !out_valid || !out_stall;
  assign q_pop   = advance && (byte_idx == 2'd0) && !q_empty;

  always_comb begin
    unique case (byte_idx)
      2'd1:    next_byte = cur.cmd;
      2'd2:    next_byte = cur.operand;
      2'd3:    next_byte = START_BYTE ^ cur.cmd ^ cur.operand;
      default: next_byte = START_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (advance) begin
      out_item.packet_byte <= next_byte;
      out_item.last_byte   <= (byte_idx == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx  <= 2'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (byte_idx != 2'd0) begin
        byte_idx  <= byte_idx + 2'd1;
        out_valid <= 1'b1;
      end else if (!q_empty) begin
        byte_idx  <= 2'd1;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/encoder_delta_command_packetizer_top.sv
// A packet passes the packet queue; its first byte is then registered at out_item.
// Throughput: one item per cycle while no packet is produced and the packet queue
// is not full; each packet holds the byte serializer for its four bytes.
// A 2-entry packet queue lets the front keep taking items during a packet.
// Reset (rst, synchronous): stored counts and times cleared, registers to defaults.
module encoder_delta_command_packetizer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  edcp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output edcp_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import edcp_pkg::*;

  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  pkt_t    q_wr_data;
  pkt_t    q_rd_data;
  logic    q_push;
  logic    q_pop;

  assign q_ctrl = '{push: q_push, pop: q_pop};

  edcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  edcp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_data (q_wr_data),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  edcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rd_data),
    .q_empty   (q_stat.empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
